[rtl/backlight_power_save_controller_top_assert.svh]
// Assertion macros for the backlight power-save controller.
// Each macro checks on the rising edge of aclk and is disabled while aresetn is low.
`ifndef BACKLIGHT_POWER_SAVE_CONTROLLER_TOP_ASSERT_SVH
`define BACKLIGHT_POWER_SAVE_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication
`define BLPS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BLPS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/blps_pkg.sv]
// ----------------------------------------------------------------------------
// blps_pkg
// Shared types, codes and constants of the backlight power-save controller.
// ----------------------------------------------------------------------------
package blps_pkg;

    // Counter sizing
    localparam int BATTERY_CHECK_TICKS = 1000;
    localparam int IDLE_COUNT_BITS     = 22;
    localparam int BCHK_BITS           = $clog2(BATTERY_CHECK_TICKS + 1);
    localparam int TIMEOUT_BITS        = 22;
    localparam int CMP_BITS = (IDLE_COUNT_BITS > TIMEOUT_BITS) ? IDLE_COUNT_BITS
                                                                : TIMEOUT_BITS;

    // APB port sizing
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;

    // Register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_MODE_FLAGS   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_DIM_TIMEOUT  = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_OFF_TIMEOUT  = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_DIM_LEVEL    = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_FULL_LEVEL   = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_BAT_DIM      = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_BAT_THRESH   = 3'd6;

    // Register reset values
    localparam logic [2:0]              MODE_FLAGS_RST  = 3'd1;
    localparam logic [TIMEOUT_BITS-1:0] DIM_TIMEOUT_RST = 22'd30000;
    localparam logic [TIMEOUT_BITS-1:0] OFF_TIMEOUT_RST = 22'd60000;
    localparam logic [7:0]              DIM_LEVEL_RST   = 8'd30;
    localparam logic [7:0]              FULL_LEVEL_RST  = 8'd255;
    localparam logic [7:0]              BAT_DIM_RST     = 8'd20;
    localparam logic [6:0]              BAT_THRESH_RST  = 7'd20;

    // Mode flag bit positions
    localparam int MODE_PSAVE = 0;
    localparam int MODE_OFF   = 1;
    localparam int MODE_BATT  = 2;

    // Request codes
    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_ACTIVITY = 2'd1;
    localparam logic [1:0] REQ_WAKE     = 2'd2;
    localparam logic [1:0] REQ_TOGGLE   = 2'd3;

    // Screen state codes
    localparam logic [1:0] SCR_ON  = 2'd0;
    localparam logic [1:0] SCR_DIM = 2'd1;
    localparam logic [1:0] SCR_OFF = 2'd2;

    typedef struct packed {
        logic [2:0]              mode_flags;
        logic [TIMEOUT_BITS-1:0] dim_timeout;
        logic [TIMEOUT_BITS-1:0] off_timeout;
        logic [7:0]              dim_level;
        logic [7:0]              full_level;
        logic [7:0]              bat_dim_level;
        logic [6:0]              bat_threshold;
    } cfg_t;

    typedef struct packed {
        logic [7:0] level;
        logic       level_written;
        logic [1:0] screen_state;
        logic       battery_mode;
        logic       manual_off;
    } result_t;

endpackage

[rtl/blps_regs.sv]
// ----------------------------------------------------------------------------
// blps_regs
// APB configuration register file; writes in the access phase, reads back.
// ----------------------------------------------------------------------------
module blps_regs import blps_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t                    cfg_reg;
    logic                    wr_en;
    logic [REG_IDX_BITS-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[APB_ADDR_BITS-1:2];
    assign cfg    = cfg_reg;

    // Write the addressed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode_flags    <= MODE_FLAGS_RST;
            cfg_reg.dim_timeout   <= DIM_TIMEOUT_RST;
            cfg_reg.off_timeout   <= OFF_TIMEOUT_RST;
            cfg_reg.dim_level     <= DIM_LEVEL_RST;
            cfg_reg.full_level    <= FULL_LEVEL_RST;
            cfg_reg.bat_dim_level <= BAT_DIM_RST;
            cfg_reg.bat_threshold <= BAT_THRESH_RST;
        end else if (wr_en) begin
            case (idx)
                REG_MODE_FLAGS:  cfg_reg.mode_flags    <= pwdata[2:0];
                REG_DIM_TIMEOUT: cfg_reg.dim_timeout   <= pwdata[TIMEOUT_BITS-1:0];
                REG_OFF_TIMEOUT: cfg_reg.off_timeout   <= pwdata[TIMEOUT_BITS-1:0];
                REG_DIM_LEVEL:   cfg_reg.dim_level     <= pwdata[7:0];
                REG_FULL_LEVEL:  cfg_reg.full_level    <= pwdata[7:0];
                REG_BAT_DIM:     cfg_reg.bat_dim_level <= pwdata[7:0];
                REG_BAT_THRESH:  cfg_reg.bat_threshold <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        prdata = '0;
        case (idx)
            REG_MODE_FLAGS:  prdata = APB_DATA_BITS'(cfg_reg.mode_flags);
            REG_DIM_TIMEOUT: prdata = APB_DATA_BITS'(cfg_reg.dim_timeout);
            REG_OFF_TIMEOUT: prdata = APB_DATA_BITS'(cfg_reg.off_timeout);
            REG_DIM_LEVEL:   prdata = APB_DATA_BITS'(cfg_reg.dim_level);
            REG_FULL_LEVEL:  prdata = APB_DATA_BITS'(cfg_reg.full_level);
            REG_BAT_DIM:     prdata = APB_DATA_BITS'(cfg_reg.bat_dim_level);
            REG_BAT_THRESH:  prdata = APB_DATA_BITS'(cfg_reg.bat_threshold);
            default:         prdata = '0;
        endcase
    end

endmodule

[rtl/blps_core.sv]
// ----------------------------------------------------------------------------
// blps_core
// Controller state and its update for one accepted word.
// ----------------------------------------------------------------------------
module blps_core import blps_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_fire,
    input  logic [1:0] req_type,
    input  logic [6:0] battery_pct,
    output result_t    result
);

    localparam logic [IDLE_COUNT_BITS-1:0] IDLE_MAX   = '1;
    localparam logic [BCHK_BITS-1:0]       BCHK_TICKS = BCHK_BITS'(BATTERY_CHECK_TICKS);

    logic [IDLE_COUNT_BITS-1:0] idle_reg, idle_next;
    logic [BCHK_BITS-1:0]       bchk_reg, bchk_next;
    logic                       dim_reg, dim_next;
    logic                       off_reg, off_next;
    logic                       lbm_reg, lbm_next;
    logic                       held_reg, held_next;
    logic [7:0]                 lvl_reg, lvl_next;
    logic                       wrote;
    logic                       bat_done;
    logic                       pct_low;
    logic                       idle_lt_dim;
    logic                       idle_lt_off;

    assign pct_low = battery_pct < cfg.bat_threshold;

    // Next state for the incoming word
    always_comb begin
        idle_next   = idle_reg;
        bchk_next   = bchk_reg;
        dim_next    = dim_reg;
        off_next    = off_reg;
        lbm_next    = lbm_reg;
        held_next   = held_reg;
        lvl_next    = lvl_reg;
        wrote       = 1'b0;
        bat_done    = 1'b0;
        idle_lt_dim = 1'b0;
        idle_lt_off = 1'b0;
        case (req_type)
            REQ_TICK: begin
                // Advance both counters, saturating
                if (idle_reg != IDLE_MAX) begin
                    idle_next = idle_reg + 1'b1;
                end
                if (bchk_reg < BCHK_TICKS) begin
                    bchk_next = bchk_reg + 1'b1;
                end
                idle_lt_dim = CMP_BITS'(idle_next) < CMP_BITS'(cfg.dim_timeout);
                idle_lt_off = CMP_BITS'(idle_next) < CMP_BITS'(cfg.off_timeout);
                if (cfg.mode_flags[MODE_PSAVE] && !held_reg) begin
                    // Periodic battery check
                    if (cfg.mode_flags[MODE_BATT] && bchk_next >= BCHK_TICKS) begin
                        bchk_next = '0;
                        if (pct_low && !lbm_reg) begin
                            lbm_next = 1'b1;
                            bat_done = 1'b1;
                            if (!dim_reg) begin
                                lvl_next = cfg.bat_dim_level;
                                wrote    = 1'b1;
                                dim_next = 1'b1;
                                off_next = 1'b0;
                            end
                        end else if (!pct_low && lbm_reg) begin
                            lbm_next = 1'b0;
                            bat_done = 1'b1;
                            if (dim_reg && idle_lt_dim) begin
                                lvl_next = cfg.full_level;
                                wrote    = 1'b1;
                                dim_next = 1'b0;
                                off_next = 1'b0;
                            end
                        end
                    end
                    // Inactivity timeouts
                    if (!bat_done && !lbm_reg) begin
                        if (cfg.mode_flags[MODE_OFF] && !idle_lt_off) begin
                            if (!off_reg) begin
                                lvl_next = '0;
                                wrote    = 1'b1;
                                dim_next = 1'b1;
                                off_next = 1'b1;
                            end
                        end else if (!idle_lt_dim) begin
                            if (!dim_reg) begin
                                lvl_next = cfg.dim_level;
                                wrote    = 1'b1;
                                dim_next = 1'b1;
                                off_next = 1'b0;
                            end
                        end else if (dim_reg || off_reg) begin
                            lvl_next = cfg.full_level;
                            wrote    = 1'b1;
                            dim_next = 1'b0;
                            off_next = 1'b0;
                        end
                    end
                end
            end
            REQ_ACTIVITY: begin
                idle_next = '0;
                if (held_reg || ((dim_reg || off_reg) && !lbm_reg)) begin
                    held_next = 1'b0;
                    lbm_next  = 1'b0;
                    if (dim_reg || off_reg) begin
                        lvl_next = cfg.full_level;
                        wrote    = 1'b1;
                        dim_next = 1'b0;
                        off_next = 1'b0;
                    end
                end
            end
            REQ_WAKE: begin
                held_next = 1'b0;
                idle_next = '0;
                lbm_next  = 1'b0;
                if (dim_reg || off_reg) begin
                    lvl_next = cfg.full_level;
                    wrote    = 1'b1;
                    dim_next = 1'b0;
                    off_next = 1'b0;
                end
            end
            REQ_TOGGLE: begin
                if (held_reg) begin
                    held_next = 1'b0;
                    idle_next = '0;
                    lbm_next  = 1'b0;
                    if (dim_reg || off_reg) begin
                        lvl_next = cfg.full_level;
                        wrote    = 1'b1;
                        dim_next = 1'b0;
                        off_next = 1'b0;
                    end
                end else begin
                    held_next = 1'b1;
                    lvl_next  = '0;
                    wrote     = 1'b1;
                    dim_next  = 1'b1;
                    off_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Commit state on an accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_reg <= '0;
            bchk_reg <= '0;
            dim_reg  <= 1'b0;
            off_reg  <= 1'b0;
            lbm_reg  <= 1'b0;
            held_reg <= 1'b0;
            lvl_reg  <= FULL_LEVEL_RST;
        end else if (in_fire) begin
            idle_reg <= idle_next;
            bchk_reg <= bchk_next;
            dim_reg  <= dim_next;
            off_reg  <= off_next;
            lbm_reg  <= lbm_next;
            held_reg <= held_next;
            lvl_reg  <= lvl_next;
        end
    end

    // Result word from the updated state
    always_comb begin
        result.level         = lvl_next;
        result.level_written = wrote;
        result.screen_state  = off_next ? SCR_OFF : (dim_next ? SCR_DIM : SCR_ON);
        result.battery_mode  = lbm_next;
        result.manual_off    = held_next;
    end

endmodule

[rtl/blps_out.sv]
// ----------------------------------------------------------------------------
// blps_out
// Output register holding one result word until the sink takes it.
// ----------------------------------------------------------------------------
module blps_out import blps_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_fire,
    input  result_t result,
    input  logic    m_ready,
    output logic    m_valid,
    output result_t m_word
);

    logic    valid_reg;
    result_t word_reg;

    assign m_valid = valid_reg;
    assign m_word  = word_reg;

    // Load on accept, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_fire) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Hold payload until replaced
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            word_reg <= result;
        end
    end

endmodule

[rtl/backlight_power_save_controller_top.sv]
// Output: a result word appears on m_* in the cycle after its input word is accepted.
// Throughput: one word per cycle; the single output register is refilled in the same
// cycle it is drained, so s_ready only drops while a result waits and m_ready is low.
// Reset: synchronous, active-low aresetn clears counters and flags, sets the level to
// 255 and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// backlight_power_save_controller_top
// Inactivity and low-battery backlight dimmer with APB configuration.
// ----------------------------------------------------------------------------
`include "backlight_power_save_controller_top_assert.svh"

module backlight_power_save_controller_top import blps_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    // Input channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_req_type,
    input  logic [6:0]               s_battery_pct,
    // Result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_level,
    output logic                     m_level_written,
    output logic [1:0]               m_screen_state,
    output logic                     m_battery_mode,
    output logic                     m_manual_off
);

    cfg_t    cfg;
    result_t result;
    result_t m_word;
    logic    in_fire;

    // Accept while the output register is free or being drained
    assign s_ready = !m_valid || m_ready;
    assign in_fire = s_valid && s_ready;

    blps_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    blps_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_fire     (in_fire),
        .req_type    (s_req_type),
        .battery_pct (s_battery_pct),
        .result      (result)
    );

    blps_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .result  (result),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_word  (m_word)
    );

    assign m_level         = m_word.level;
    assign m_level_written = m_word.level_written;
    assign m_screen_state  = m_word.screen_state;
    assign m_battery_mode  = m_word.battery_mode;
    assign m_manual_off    = m_word.manual_off;

    // Every accepted word yields a result on the next cycle
    `BLPS_ASSERT_NXT(a_fire_gives_result, in_fire, m_valid, "accepted word gave no result")
    // Screen off always drives a zero level
    `BLPS_ASSERT_IMP(a_off_is_dark, m_valid && (m_screen_state == SCR_OFF), m_level == 8'd0, "screen off with nonzero level")
    // Manual off holds the screen off
    `BLPS_ASSERT_IMP(a_manual_is_off, m_valid && m_manual_off, m_screen_state == SCR_OFF, "manual off but screen not off")
    // Battery mode never leaves the screen fully on
    `BLPS_ASSERT_IMP(a_batt_not_on, m_valid && m_battery_mode, m_screen_state != SCR_ON, "battery mode with screen on")

endmodule

[bench/backlight_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Backlight controller checker
// Watches the configuration port and both word channels, predicts each result
// word of the backlight controller and compares it field by field.
// ----------------------------------------------------------------------------
module backlight_checker import blps_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [1:0]               s_req_type,
    input  logic [6:0]               s_battery_pct,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [7:0]               m_level,
    input  logic                     m_level_written,
    input  logic [1:0]               m_screen_state,
    input  logic                     m_battery_mode,
    input  logic                     m_manual_off,
    output int                       mismatches,
    output int                       words_due,
    output int                       words_checked
);

    // Shadow configuration and controller state
    cfg_t                       cfg;
    logic [IDLE_COUNT_BITS-1:0] idle_ms;
    logic [BCHK_BITS-1:0]       check_count;
    logic                       dimmed;
    logic                       screen_off;
    logic                       low_batt;
    logic                       held_off;
    logic                       wrote;
    logic [7:0]                 level_now;
    result_t                    backlight_due[$];

    function automatic void set_level(input logic [7:0] lvl);
        level_now = lvl;
        wrote = 1'b1;
    endfunction

    // Dim only once; the low-battery level wins while battery mode is on
    function automatic void enter_dim();
        if (!dimmed) begin
            set_level(low_batt ? cfg.bat_dim_level : cfg.dim_level);
            dimmed = 1'b1;
            screen_off = 1'b0;
        end
    endfunction

    function automatic void enter_off();
        set_level(8'd0);
        dimmed = 1'b1;
        screen_off = 1'b1;
    endfunction

    function automatic void wake_up();
        if (dimmed || screen_off) begin
            set_level(cfg.full_level);
            dimmed = 1'b0;
            screen_off = 1'b0;
        end
        low_batt = 1'b0;
    endfunction

    // Counters advance on every tick; decisions only when enabled and not held
    function automatic void count_tick(input logic [6:0] pct);
        if (idle_ms != {IDLE_COUNT_BITS{1'b1}})
            idle_ms = idle_ms + 1'b1;
        if (check_count < BATTERY_CHECK_TICKS)
            check_count = check_count + 1'b1;
        if (!cfg.mode_flags[MODE_PSAVE] || held_off)
            return;
        // Battery check; a change of battery mode ends the tick
        if (cfg.mode_flags[MODE_BATT] && check_count >= BATTERY_CHECK_TICKS) begin
            check_count = '0;
            if (pct < cfg.bat_threshold && !low_batt) begin
                low_batt = 1'b1;
                enter_dim();
                return;
            end else if (pct >= cfg.bat_threshold && low_batt) begin
                low_batt = 1'b0;
                if (dimmed && idle_ms < cfg.dim_timeout)
                    wake_up();
                return;
            end
        end
        if (!low_batt) begin
            if (cfg.mode_flags[MODE_OFF] && idle_ms >= cfg.off_timeout) begin
                if (!screen_off)
                    enter_off();
            end else if (idle_ms >= cfg.dim_timeout) begin
                enter_dim();
            end else if (dimmed || screen_off) begin
                wake_up();
            end
        end
    endfunction

    function automatic result_t predict_backlight(input logic [1:0] req,
                                                  input logic [6:0] pct);
        result_t r;
        wrote = 1'b0;
        case (req)
            REQ_TICK: begin
                count_tick(pct);
            end
            REQ_ACTIVITY: begin
                idle_ms = '0;
                if (held_off) begin
                    held_off = 1'b0;
                    wake_up();
                end else if ((dimmed || screen_off) && !low_batt) begin
                    wake_up();
                end
            end
            REQ_WAKE: begin
                held_off = 1'b0;
                idle_ms = '0;
                wake_up();
            end
            default: begin
                // Manual-off toggle
                if (held_off) begin
                    held_off = 1'b0;
                    idle_ms = '0;
                    wake_up();
                end else begin
                    held_off = 1'b1;
                    enter_off();
                end
            end
        endcase
        r.level         = level_now;
        r.level_written = wrote;
        r.screen_state  = screen_off ? SCR_OFF : (dimmed ? SCR_DIM : SCR_ON);
        r.battery_mode  = low_batt;
        r.manual_off    = held_off;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Track register writes, check drained words, predict accepted words
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            cfg.mode_flags    = MODE_FLAGS_RST;
            cfg.dim_timeout   = DIM_TIMEOUT_RST;
            cfg.off_timeout   = OFF_TIMEOUT_RST;
            cfg.dim_level     = DIM_LEVEL_RST;
            cfg.full_level    = FULL_LEVEL_RST;
            cfg.bat_dim_level = BAT_DIM_RST;
            cfg.bat_threshold = BAT_THRESH_RST;
            idle_ms     = '0;
            check_count = '0;
            dimmed      = 1'b0;
            screen_off  = 1'b0;
            low_batt    = 1'b0;
            held_off    = 1'b0;
            wrote       = 1'b0;
            level_now   = FULL_LEVEL_RST;
            backlight_due.delete();
            words_due = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_BITS-1:2])
                    REG_MODE_FLAGS:  cfg.mode_flags    = pwdata[2:0];
                    REG_DIM_TIMEOUT: cfg.dim_timeout   = pwdata[TIMEOUT_BITS-1:0];
                    REG_OFF_TIMEOUT: cfg.off_timeout   = pwdata[TIMEOUT_BITS-1:0];
                    REG_DIM_LEVEL:   cfg.dim_level     = pwdata[7:0];
                    REG_FULL_LEVEL:  cfg.full_level    = pwdata[7:0];
                    REG_BAT_DIM:     cfg.bat_dim_level = pwdata[7:0];
                    REG_BAT_THRESH:  cfg.bat_threshold = pwdata[6:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (backlight_due.size() == 0) begin
                    $error("result word arrived with no word pending");
                    mismatches++;
                end else begin
                    want = backlight_due.pop_front();
                    check_field("level", want.level, m_level);
                    check_field("level_written", 8'(want.level_written),
                                8'(m_level_written));
                    check_field("screen_state", 8'(want.screen_state), 8'(m_screen_state));
                    check_field("battery_mode", 8'(want.battery_mode), 8'(m_battery_mode));
                    check_field("manual_off", 8'(want.manual_off), 8'(m_manual_off));
                    words_checked++;
                end
            end
            if (s_valid && s_ready)
                backlight_due.push_back(predict_backlight(s_req_type, s_battery_pct));
            words_due = backlight_due.size();
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Backlight power-save controller testbench
// Drives ticks, activity, wake and manual-off words under changing register
// settings, with random gaps and stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import blps_pkg::*;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     psel          = 1'b0;
    logic                     penable       = 1'b0;
    logic                     pwrite        = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr         = '0;
    logic [APB_DATA_BITS-1:0] pwdata        = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_req_type    = REQ_TICK;
    logic [6:0]               s_battery_pct = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic [7:0]               m_level;
    logic                     m_level_written;
    logic [1:0]               m_screen_state;
    logic                     m_battery_mode;
    logic                     m_manual_off;

    logic s_taken = 1'b0;
    logic steady  = 1'b0;
    int   mismatches, words_due, words_checked;
    int   words_sent, ticks_sent, settings;

    // Mirror of the current settings, used to shape the stimulus
    logic [2:0]  mode;
    logic [21:0] dim_to, off_to;
    logic [7:0]  dim_lv, full_lv, bat_lv;
    logic [6:0]  thr = BAT_THRESH_RST;

    backlight_power_save_controller_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_battery_pct(s_battery_pct),
        .m_valid(m_valid), .m_ready(m_ready), .m_level(m_level),
        .m_level_written(m_level_written), .m_screen_state(m_screen_state),
        .m_battery_mode(m_battery_mode), .m_manual_off(m_manual_off)
    );

    backlight_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_battery_pct(s_battery_pct),
        .m_valid(m_valid), .m_ready(m_ready), .m_level(m_level),
        .m_level_written(m_level_written), .m_screen_state(m_screen_state),
        .m_battery_mode(m_battery_mode), .m_manual_off(m_manual_off),
        .mismatches(mismatches), .words_due(words_due), .words_checked(words_checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Remember whether the last edge accepted an input word
    always @(posedge aclk) begin
        s_taken <= s_valid && s_ready;
    end

    // Stall the result side now and then, except in the steady stretch
    always @(negedge aclk) begin
        m_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 7);
    end

    task automatic apb_write(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic pause(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // Hold the word until the block takes it
    task automatic send_word(input logic [1:0] req, input logic [6:0] pct);
        if (!steady && $urandom_range(0, 99) < 7)
            pause($urandom_range(1, 3));
        s_req_type    <= req;
        s_battery_pct <= pct;
        s_valid       <= 1'b1;
        do @(negedge aclk); while (!s_taken);
        words_sent++;
        if (req == REQ_TICK)
            ticks_sent++;
    endtask

    // Drop valid and wait until every result word has been drained
    task automatic drain();
        s_valid <= 1'b0;
        for (int n = 0; n < 5000 && words_due != 0; n++)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    function automatic logic [21:0] pick_timeout();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 22'($urandom_range(0, 40));
        else if (r < 90)
            return 22'($urandom_range(1000, 1200));
        return 22'($urandom_range(0, 22'h3FFFFF));
    endfunction

    // Mostly close to the threshold so both sides of it show up on checks
    function automatic logic [6:0] pick_pct();
        int p;
        if ($urandom_range(0, 99) < 80) begin
            p = int'(thr) + int'($urandom_range(0, 6)) - 3;
            if (p < 0)
                p = 0;
            if (p > 127)
                p = 127;
            return 7'(p);
        end
        return 7'($urandom_range(0, 127));
    endfunction

    initial begin
        int run, r, phase;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: every request at reset settings, manual off held and released
        send_word(REQ_TICK, 7'd0);
        send_word(REQ_ACTIVITY, 7'd127);
        send_word(REQ_TOGGLE, 7'd100);
        send_word(REQ_TICK, 7'd0);
        send_word(REQ_ACTIVITY, 7'd0);
        send_word(REQ_TOGGLE, 7'd0);
        send_word(REQ_TOGGLE, 7'd0);
        send_word(REQ_TOGGLE, 7'd0);
        send_word(REQ_WAKE, 7'd0);
        send_word(REQ_WAKE, 7'd127);
        // Zero dim timeout dims on the first tick
        drain();
        apb_write(REG_DIM_TIMEOUT, 32'd0);
        send_word(REQ_TICK, 7'd127);
        send_word(REQ_TICK, 7'd0);
        send_word(REQ_ACTIVITY, 7'd0);
        send_word(REQ_TICK, 7'd0);
        // Zero off timeout with screen-off enabled
        drain();
        apb_write(REG_MODE_FLAGS, 32'd3);
        apb_write(REG_OFF_TIMEOUT, 32'd0);
        send_word(REQ_TICK, 7'd0);
        send_word(REQ_TICK, 7'd0);
        send_word(REQ_WAKE, 7'd0);
        send_word(REQ_TOGGLE, 7'd0);
        send_word(REQ_TICK, 7'd0);
        send_word(REQ_TOGGLE, 7'd0);
        // Power save disabled: ticks change nothing
        drain();
        apb_write(REG_MODE_FLAGS, 32'd0);
        send_word(REQ_TICK, 7'd127);
        send_word(REQ_ACTIVITY, 7'd127);

        // Random: tick runs, mostly followed by an event, new settings every 10 runs
        for (int seq = 0; seq < 80; seq++) begin
            if (seq % 10 == 0) begin
                phase = seq / 10;
                drain();
                case (phase)
                    0: begin
                        mode = 3'd7; dim_to = 22'd0; off_to = 22'd0;
                        dim_lv = 8'd0; full_lv = 8'd0; bat_lv = 8'd0; thr = 7'd127;
                    end
                    1: begin
                        mode = 3'd7; dim_to = 22'h3FFFFF; off_to = 22'h3FFFFF;
                        dim_lv = 8'd255; full_lv = 8'd255; bat_lv = 8'd255; thr = 7'd0;
                    end
                    2: begin
                        mode = 3'd7; dim_to = 22'd1000; off_to = 22'd3600000;
                        dim_lv = 8'd255; full_lv = 8'd0; bat_lv = 8'd255; thr = 7'd100;
                    end
                    3: begin
                        mode = 3'd3; dim_to = 22'd1000; off_to = 22'd1000;
                        dim_lv = 8'd1; full_lv = 8'd254; bat_lv = 8'd128; thr = 7'd50;
                    end
                    default: begin
                        mode = ($urandom_range(0, 1) == 0) ? 3'd7 : 3'($urandom_range(0, 7));
                        dim_to = pick_timeout();
                        off_to = pick_timeout();
                        dim_lv = 8'($urandom_range(0, 255));
                        full_lv = 8'($urandom_range(0, 255));
                        bat_lv = 8'($urandom_range(0, 255));
                        thr = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(101, 127))
                                                          : 7'($urandom_range(0, 100));
                    end
                endcase
                apb_write(REG_MODE_FLAGS, 32'(mode));
                apb_write(REG_DIM_TIMEOUT, 32'(dim_to));
                apb_write(REG_OFF_TIMEOUT, 32'(off_to));
                apb_write(REG_DIM_LEVEL, 32'(dim_lv));
                apb_write(REG_FULL_LEVEL, 32'(full_lv));
                apb_write(REG_BAT_DIM, 32'(bat_lv));
                apb_write(REG_BAT_THRESH, 32'(thr));
                steady <= (phase == 4);
                settings++;
            end

            // Short tick runs reach the small timeouts between events
            r = $urandom_range(0, 99);
            if (r < 70) begin
                run = $urandom_range(0, 8);
            end else begin
                run = $urandom_range(9, 20);
            end
            repeat (run) send_word(REQ_TICK, pick_pct());

            r = $urandom_range(0, 99);
            if (r < 40)
                send_word(REQ_ACTIVITY, 7'($urandom_range(0, 127)));
            else if (r < 55)
                send_word(REQ_WAKE, 7'($urandom_range(0, 127)));
            else if (r < 80)
                send_word(REQ_TOGGLE, 7'($urandom_range(0, 127)));
        end

        drain();
        repeat (5) @(negedge aclk);

        $display("Checked %0d result words from %0d input words (%0d ticks).",
                 words_checked, words_sent, ticks_sent);
        $display("Covered %0d register settings plus directed zero-timeout cases.",
                 settings);
        if (mismatches == 0 && words_due == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Give up if the run hangs
    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/blps_pkg.sv
rtl/blps_regs.sv
rtl/blps_core.sv
rtl/blps_out.sv
rtl/backlight_power_save_controller_top.sv
bench/backlight_checker.sv
bench/testbench.sv
